FILE: design/sorted_occurrence_table_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted occurrence table
// Wrappers that give every concurrent check the same clock, reset and report.
// ----------------------------------------------------------------------------
`ifndef SORTED_OCCURRENCE_TABLE_CORE_ASSERT_SVH
`define SORTED_OCCURRENCE_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SOT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted occurrence table check failed");

// Next-cycle implication, disabled while reset is high.
`define SOT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted occurrence table check failed");

`endif

FILE: design/sot_pkg.sv
// ----------------------------------------------------------------------------
// Sorted occurrence table package
// Field widths, parameter defaults and the command word of the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package sot_pkg;

   // Fixed widths of the transfer fields.
   localparam int DOC_ID_BITS = 16;
   localparam int SLOT_BITS   = 6;
   localparam int OCC_BITS    = 16;
   localparam int TOTAL_BITS  = 7;

   // Defaults of the top-level parameters.
   localparam int MAX_ENTRIES_DEFAULT = 64;
   localparam int ID_BITS_DEFAULT     = 16;
   localparam int COUNT_BITS_DEFAULT  = 16;

   // Command broadcast from the sequencer to every cell.
   typedef struct packed {
      logic compare;  // latch less-than and equal flags against the key
      logic insert;   // open a gap at the boundary and write the key there
      logic bump;     // increment the count of the matching cell
   } cell_cmd_type;

endpackage

`default_nettype wire

FILE: design/sot_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Carries one document id per transfer with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface sot_req_if;
   logic                              valid;
   logic                              ready;
   logic [sot_pkg::DOC_ID_BITS-1:0]   doc_id;

   modport source (output valid, output doc_id, input ready);
   modport sink   (input valid, input doc_id, output ready);
endinterface

`default_nettype wire

FILE: design/sot_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Carries one table result per transfer with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface sot_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [sot_pkg::SLOT_BITS-1:0]     slot;
   logic [sot_pkg::OCC_BITS-1:0]      occurrences;
   logic                              is_new;
   logic                              overflow;
   logic [sot_pkg::TOTAL_BITS-1:0]    entry_total;

   modport source (output valid, output slot, output occurrences, output is_new,
                   output overflow, output entry_total, input ready);
   modport sink   (input valid, input slot, input occurrences, input is_new,
                   input overflow, input entry_total, output ready);
endinterface

`default_nettype wire

FILE: design/sorted_occurrence_table_core.sv
// ----------------------------------------------------------------------------
// Sorted occurrence table core
// Posting list of (document id, count) pairs kept in ascending id order.
// ----------------------------------------------------------------------------
//  Channel    Direction  Payload                                          
//  req_port   in         doc_id                                           
//  rsp_port   out        slot, occurrences, is_new, overflow, entry_total 
//
//  Each id goes through the transfer, a compare cycle in which every
//  cell checks its entry against the id, and an update cycle that shifts or
//  increments and loads the result register. A new id is taken only after
//  the update, which waits while the result register holds an untaken
//  result. Reset empties the table at once; no clearing pass is needed.
`default_nettype none

`include "sorted_occurrence_table_core_assert.svh"

module sorted_occurrence_table_core #(
   parameter int MAX_ENTRIES = sot_pkg::MAX_ENTRIES_DEFAULT,
   parameter int ID_BITS     = sot_pkg::ID_BITS_DEFAULT,
   parameter int COUNT_BITS  = sot_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   sot_req_if.sink    req_port,
   sot_rsp_if.source  rsp_port
);

   localparam int IW = $clog2(MAX_ENTRIES);
   localparam int UW = $clog2(MAX_ENTRIES + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CMP  = 2'd1;
   localparam logic [1:0] ST_UPD  = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [ID_BITS-1:0]     key_ff, key_in;
   logic [UW-1:0]          used_ff, used_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [sot_pkg::SLOT_BITS-1:0]       slot_ff, slot_in;
   logic [sot_pkg::OCC_BITS-1:0]        occ_ff, occ_in;
   logic                                is_new_ff, is_new_in;
   logic                                overflow_ff, overflow_in;
   logic [sot_pkg::TOTAL_BITS-1:0]      total_ff, total_in;

   sot_pkg::cell_cmd_type  cmd;
   logic [MAX_ENTRIES-1:0] valid_vec;
   logic [MAX_ENTRIES-1:0] lt_vec;
   logic [MAX_ENTRIES-1:0] eq_vec;
   logic [MAX_ENTRIES-1:0] bnd_vec;
   logic [MAX_ENTRIES-1:0] sel_vec;
   logic [ID_BITS-1:0]     id_vec    [MAX_ENTRIES];
   logic [COUNT_BITS-1:0]  count_vec [MAX_ENTRIES];
   logic [COUNT_BITS-1:0]  plus_vec  [MAX_ENTRIES];

   logic                   hit;
   logic                   full;
   logic                   do_insert;
   logic                   upd_go;
   logic [IW-1:0]          sel_idx;
   logic [COUNT_BITS-1:0]  hit_count;

   // Request handshake and sequencer.
   assign req_port.ready = (state_ff == ST_IDLE);
   assign upd_go         = (state_ff == ST_UPD) & (~rsp_valid_ff | rsp_port.ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_port.valid) state_in = ST_CMP;
         end
         ST_CMP: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (upd_go) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The key is captured on the request transfer.
   assign key_in = (req_port.valid & req_port.ready) ? ID_BITS'(req_port.doc_id) : key_ff;

   // Decisions taken from the registered compare flags.
   assign hit       = |eq_vec;
   assign full      = (used_ff == UW'(MAX_ENTRIES));
   assign do_insert = ~hit & ~full;

   assign cmd.compare = (state_ff == ST_CMP);
   assign cmd.insert  = upd_go & do_insert;
   assign cmd.bump    = upd_go & hit;

   // Cell chain; cell zero sees an always-lower, empty neighbor.
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic                  p_lt;
      logic                  p_valid;
      logic [ID_BITS-1:0]    p_id;
      logic [COUNT_BITS-1:0] p_count;

      if (i == 0) begin : g_head
         assign p_lt    = 1'b1;
         assign p_valid = 1'b0;
         assign p_id    = key_ff;
         assign p_count = COUNT_BITS'(1);
         assign bnd_vec[i] = ~lt_vec[i];
      end else begin : g_body
         assign p_lt    = lt_vec[i-1];
         assign p_valid = valid_vec[i-1];
         assign p_id    = id_vec[i-1];
         assign p_count = count_vec[i-1];
         assign bnd_vec[i] = ~lt_vec[i] & lt_vec[i-1];
      end

      assign valid_vec[i] = (used_ff > UW'(i));

      sot_cell #(
         .ID_BITS    (ID_BITS),
         .COUNT_BITS (COUNT_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .key        (key_ff),
         .valid      (valid_vec[i]),
         .prev_lt    (p_lt),
         .prev_valid (p_valid),
         .prev_id    (p_id),
         .prev_count (p_count),
         .lt_out     (lt_vec[i]),
         .eq_out     (eq_vec[i]),
         .id_out     (id_vec[i]),
         .count_out  (count_vec[i]),
         .count_plus (plus_vec[i])
      );
   end

   // One-hot slot select: the matching cell on a hit, else the boundary.
   assign sel_vec = hit ? eq_vec : bnd_vec;

   always_comb begin
      sel_idx   = '0;
      hit_count = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (sel_vec[i]) sel_idx = sel_idx | IW'(i);
         if (eq_vec[i])  hit_count = hit_count | plus_vec[i];
      end
   end

   // Entry count and result register.
   assign used_in = (upd_go & do_insert) ? used_ff + UW'(1) : used_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_port.ready;
      slot_in      = slot_ff;
      occ_in       = occ_ff;
      is_new_in    = is_new_ff;
      overflow_in  = overflow_ff;
      total_in     = total_ff;
      if (upd_go) begin
         rsp_valid_in = 1'b1;
         slot_in      = full & ~hit ? '0 : sot_pkg::SLOT_BITS'(sel_idx);
         priority if (hit) begin
            occ_in = sot_pkg::OCC_BITS'(hit_count);
         end else if (do_insert) begin
            occ_in = sot_pkg::OCC_BITS'(1);
         end else begin
            occ_in = '0;
         end
         is_new_in    = do_insert;
         overflow_in  = full & ~hit;
         total_in     = sot_pkg::TOTAL_BITS'(used_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      slot_ff     <= slot_in;
      occ_ff      <= occ_in;
      is_new_ff   <= is_new_in;
      overflow_ff <= overflow_in;
      total_ff    <= total_in;
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.slot        = slot_ff;
   assign rsp_port.occurrences = occ_ff;
   assign rsp_port.is_new      = is_new_ff;
   assign rsp_port.overflow    = overflow_ff;
   assign rsp_port.entry_total = total_ff;

   // Sorted order means at most one cell matches and at most one boundary exists.
   `SOT_ASSERT_NOW(a_single_match, clock, reset, state_ff == ST_UPD, $onehot0(eq_vec))
   `SOT_ASSERT_NOW(a_single_boundary, clock, reset, state_ff == ST_UPD && !hit,
                   $onehot0(bnd_vec))
   // The fill count never passes the table depth.
   `SOT_ASSERT_NOW(a_used_bound, clock, reset, 1'b1, used_ff <= UW'(MAX_ENTRIES))
   // An insertion grows the table by exactly one entry.
   `SOT_ASSERT_NEXT(a_insert_grows, clock, reset, upd_go && do_insert,
                    used_ff == $past(used_ff) + UW'(1))
   // A finished update always leaves a result waiting.
   `SOT_ASSERT_NEXT(a_result_loaded, clock, reset, upd_go, rsp_valid_ff)

endmodule

`default_nettype wire

FILE: design/sot_cell.sv
// ----------------------------------------------------------------------------
// Sorted occurrence table cell
// Holds one (id, count) entry, compares it with the key and shifts up.
// ----------------------------------------------------------------------------
`default_nettype none

module sot_cell #(
   parameter int ID_BITS    = sot_pkg::ID_BITS_DEFAULT,
   parameter int COUNT_BITS = sot_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire sot_pkg::cell_cmd_type   cmd,
   input  wire logic [ID_BITS-1:0]      key,
   input  wire logic                    valid,
   input  wire logic                    prev_lt,
   input  wire logic                    prev_valid,
   input  wire logic [ID_BITS-1:0]      prev_id,
   input  wire logic [COUNT_BITS-1:0]   prev_count,
   output logic                         lt_out,
   output logic                         eq_out,
   output logic [ID_BITS-1:0]           id_out,
   output logic [COUNT_BITS-1:0]        count_out,
   output logic [COUNT_BITS-1:0]        count_plus
);

   logic [ID_BITS-1:0]    id_ff, id_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  lt_ff, lt_in;
   logic                  eq_ff, eq_in;
   logic                  take_key;
   logic                  take_prev;

   // Saturating increment of the held count.
   assign count_plus = (&count_ff) ? count_ff : count_ff + COUNT_BITS'(1);

   // The key lands where the less-than flags change from one to zero; every
   // valid entry above that point moves up by one cell.
   assign take_key  = cmd.insert & ~lt_ff & prev_lt;
   assign take_prev = cmd.insert & ~prev_lt & prev_valid;

   // Compare flags are only meaningful for cells that hold an entry.
   always_comb begin
      lt_in = lt_ff;
      eq_in = eq_ff;
      if (cmd.compare) begin
         lt_in = valid & (id_ff < key);
         eq_in = valid & (id_ff == key);
      end
   end

   // Entry update: insert, shift or count increment.
   always_comb begin
      id_in    = id_ff;
      count_in = count_ff;
      if (take_key) begin
         id_in    = key;
         count_in = COUNT_BITS'(1);
      end else if (take_prev) begin
         id_in    = prev_id;
         count_in = prev_count;
      end else if (cmd.bump & eq_ff) begin
         count_in = count_plus;
      end
   end

   always_ff @(posedge clock) begin
      id_ff    <= id_in;
      count_ff <= count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lt_ff <= 1'b0;
         eq_ff <= 1'b0;
      end else begin
         lt_ff <= lt_in;
         eq_ff <= eq_in;
      end
   end

   assign lt_out    = lt_ff;
   assign eq_out    = eq_ff;
   assign id_out    = id_ff;
   assign count_out = count_ff;

endmodule

`default_nettype wire
